>>> hdl/hbet_pkg.sv
// Shared types and constants for the HTTP body end tracker.
// Used by every module of the block; depends on nothing.
package hbet_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int TOTAL_BITS  = 40;
  localparam int TRAILER_LEN = 7;

  // Trailer that closes a chunked body: CR LF '0' CR LF CR LF.
  localparam logic [7:0] TRAILER [TRAILER_LEN] =
    '{8'h0D, 8'h0A, 8'h30, 8'h0D, 8'h0A, 8'h0D, 8'h0A};

  // Stream packing.
  localparam int IN_FIELD_BITS  = 8 + LENGTH_BITS + 1 + 1;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 1 + 1 + LENGTH_BITS + TOTAL_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Operation codes carried in tuser.
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_OPEN = 2'd1,
    MODE_LAST = 2'd2
  } mode_t;

  // Control handed from the top level to the matcher chain.
  typedef struct packed {
    logic clear;    // drop all partial matches
    logic advance;  // shift one body byte through the chain
  } match_ctrl_t;

endpackage

>>> hdl/hbet_cell.sv
// One matcher cell: remembers whether a trailer prefix ends at the last byte.
// Depends on hbet_pkg for the control struct.
module hbet_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  hbet_pkg::match_ctrl_t ctrl,
  input  logic [7:0]         data_byte,
  input  logic [7:0]         expect_char,
  input  logic               prev_hit,
  output logic               hit
);

  logic hit_r;
  logic hit_nxt;

  always_comb begin
    hit_nxt = hit_r;
    if (ctrl.clear) begin
      hit_nxt = 1'b0;
    end else if (ctrl.advance) begin
      hit_nxt = prev_hit & (data_byte == expect_char);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

>>> hdl/hbet_matcher.sv
// Chain of matcher cells that finds the chunked-body trailer in a byte stream.
// Depends on hbet_pkg and hbet_cell.
module hbet_matcher (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hbet_pkg::match_ctrl_t ctrl,
  input  logic [7:0]            data_byte,
  output logic                  trailer_done
);

  // hit[k] is set when the first k+1 trailer bytes end at the last byte.
  logic [hbet_pkg::TRAILER_LEN-2:0] hit;

  for (genvar k = 0; k < hbet_pkg::TRAILER_LEN - 1; k++) begin : g_cell
    hbet_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .data_byte   (data_byte),
      .expect_char (hbet_pkg::TRAILER[k]),
      .prev_hit    ((k == 0) ? 1'b1 : hit[(k == 0) ? 0 : k - 1]),
      .hit         (hit[k])
    );
  end

  // The last trailer byte completes the match in the same cycle.
  assign trailer_done = ctrl.advance & hit[hbet_pkg::TRAILER_LEN-2] &
                        (data_byte == hbet_pkg::TRAILER[hbet_pkg::TRAILER_LEN-1]);

endmodule

>>> hdl/http_body_end_tracker_core.sv
// HTTP body end tracker, top level. The result of an accepted beat is loaded
// into the output register. Throughput: one beat per cycle unless out_tready
// stalls the output, set by a single matcher-cell step and one counter update per beat.
// Reset (rst_n, synchronous, active low) clears the mode, counters, matcher
// cells and the output valid; no clearing pass is needed.
module http_body_end_tracker_core (
  input  logic clk,
  input  logic rst_n,

  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: data_byte[7:0], length_value[39:8], chunked_flag[40],
  // length_unknown[41], zero fill above.
  input  logic [hbet_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // Fields from bit 0: operation (0 = start of body, 1 = body byte).
  input  logic                               in_tuser,

  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0: body_expected[0], last_chunk_seen[1],
  // remaining_bytes[33:2], total_bytes[73:34], zero fill above.
  output logic [hbet_pkg::OUT_DATA_BITS-1:0] out_tdata
);

  localparam int LB = hbet_pkg::LENGTH_BITS;
  localparam int TB = hbet_pkg::TOTAL_BITS;

  // Unpacked input fields.
  logic [7:0]    data_byte;
  logic [LB-1:0] length_value;
  logic          chunked_flag;
  logic          length_unknown;

  assign data_byte      = in_tdata[7:0];
  assign length_value   = in_tdata[8 +: LB];
  assign chunked_flag   = in_tdata[8 + LB];
  assign length_unknown = in_tdata[9 + LB];

  // Tracker state.
  hbet_pkg::mode_t mode_r, mode_nxt;
  logic [LB-1:0]   left_r, left_nxt;
  logic [TB-1:0]   total_r, total_nxt;
  logic            unknown_r, unknown_nxt;

  // Output register; it takes a new result while the old one drains.
  logic                               out_valid_r;
  logic [hbet_pkg::OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;

  logic                  accept;
  logic                  trailer_done;
  hbet_pkg::match_ctrl_t mctrl;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // The matcher only moves while a chunked body is open; a start beat or a
  // completed trailer wipes its partial matches.
  assign mctrl.advance = accept && (in_tuser == hbet_pkg::OP_BYTE) &&
                         (mode_r == hbet_pkg::MODE_OPEN);
  assign mctrl.clear   = (accept && (in_tuser == hbet_pkg::OP_START)) || trailer_done;

  hbet_matcher u_matcher (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (mctrl),
    .data_byte    (data_byte),
    .trailer_done (trailer_done)
  );

  always_comb begin
    mode_nxt    = mode_r;
    left_nxt    = left_r;
    total_nxt   = total_r;
    unknown_nxt = unknown_r;
    if (accept) begin
      if (in_tuser == hbet_pkg::OP_START) begin
        mode_nxt    = chunked_flag ? hbet_pkg::MODE_OPEN : hbet_pkg::MODE_OFF;
        left_nxt    = length_value;
        total_nxt   = '0;
        unknown_nxt = length_unknown;
      end else begin
        // The byte total saturates at all ones.
        if (total_r != {TB{1'b1}}) begin
          total_nxt = total_r + TB'(1);
        end
        if (mode_r == hbet_pkg::MODE_OPEN) begin
          if (trailer_done) begin
            mode_nxt = hbet_pkg::MODE_LAST;
          end
        end else if (left_r != '0) begin
          // Outside an open chunked body the length count runs down to zero.
          left_nxt = left_r - LB'(1);
        end
      end
    end
    out_data_nxt = '0;
    out_data_nxt[0]           = unknown_nxt || (mode_nxt == hbet_pkg::MODE_OPEN) ||
                                (left_nxt != '0);
    out_data_nxt[1]           = (mode_nxt == hbet_pkg::MODE_LAST);
    out_data_nxt[2 +: LB]     = left_nxt;
    out_data_nxt[2 + LB +: TB] = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= hbet_pkg::MODE_OFF;
      left_r      <= '0;
      total_r     <= '0;
      unknown_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      left_r    <= left_nxt;
      total_r   <= total_nxt;
      unknown_r <= unknown_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
